// ===== hdl/sqe_pkg.sv =====
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared types and constants of the stack/queue engine: opcodes, status
// codes, and the request and result records passed between the parts.
// ----------------------------------------------------------------------------
package sqe_pkg;

  // default number of entries in the store
  localparam int unsigned STORE_DEPTH = 64;

  // depth of the request queue between front and back, and of the result queue
  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_POP  = 3'd1,
    OP_SWAP = 3'd2,
    OP_PEEK = 3'd3,
    OP_DUMP = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BADARG    = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_SHORT     = 3'd3,
    ST_FULL      = 3'd4,
    ST_DUMPEMPTY = 3'd5
  } status_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] value;
    logic               arg_valid;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] value;
    status_e            status;
    logic               last;
  } res_t;

endpackage

// ===== hdl/stack_queue_engine_top.sv =====
// ----------------------------------------------------------------------------
// stack_queue_engine_top
// Bounded stack of signed 32-bit entries with a queue-mode push.
// ----------------------------------------------------------------------------
// Requests enter through a small queue and are carried out one at a time by
// the back end, which keeps the entries in a store memory with one read and
// one write port and a registered read. Push, pop, every error case and the
// empty dump finish in the idle state; peek reads the top entry and returns
// it, swap reads the top two entries and writes them back swapped, and a dump
// reads and returns each stored entry in turn. Results wait in a result
// queue, so new requests keep being taken while results are not popped, until
// both queues fill. Unknown opcodes are taken and give no result. The user must
// write the queue_mode register only while the block is idle; no logic enforces it.
module stack_queue_engine_top #(
  parameter int unsigned DEPTH = sqe_pkg::STORE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               queue_mode_we_i,
  input  logic               queue_mode_i,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode_i,
  input  logic signed [31:0] push_value_i,
  input  logic               arg_valid_i,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] result_value_o,
  output logic [2:0]         status_o,
  output logic               last_of_run_o
);

  import sqe_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  sqe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .push_value_i (push_value_i),
    .arg_valid_i  (arg_valid_i),
    .cmd_o        (cmd),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop)
  );

  sqe_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (queue_mode_we_i),
    .cfg_mode_i  (queue_mode_i),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  sqe_fifo #(
    .item_t (res_t),
    .DEPTH  (RES_Q_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign result_value_o = res_out.value;
  assign status_o       = 3'(res_out.status);
  assign last_of_run_o  = res_out.last;

endmodule

// ===== hdl/sqe_fifo.sv =====
// ----------------------------------------------------------------------------
// sqe_fifo
// Small synchronous first-in first-out queue of register entries, used for
// the request queue and for the result queue.
// ----------------------------------------------------------------------------
module sqe_fifo #(
  parameter type         item_t = logic,
  parameter int unsigned DEPTH  = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t data_o,
  output logic  empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t           mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d;
  logic [PW-1:0]   rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/sqe_front.sv =====
// ----------------------------------------------------------------------------
// sqe_front
// Input side: takes requests, decodes the opcode, drops unknown opcodes and
// queues the rest for the execution back end.
// ----------------------------------------------------------------------------
module sqe_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          opcode_i,
  input  logic signed [31:0]  push_value_i,
  input  logic                arg_valid_i,
  output sqe_pkg::cmd_t       cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i
);

  import sqe_pkg::*;

  cmd_t cmd_in;
  logic known_op;
  logic cmd_empty;

  // unknown opcodes are taken and then forgotten
  assign known_op = opcode_i inside {[3'(OP_PUSH):3'(OP_DUMP)]};

  always_comb begin
    cmd_in.op        = op_e'(opcode_i);
    cmd_in.value     = push_value_i;
    cmd_in.arg_valid = arg_valid_i;
  end

  sqe_fifo #(
    .item_t (cmd_t),
    .DEPTH  (CMD_Q_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && known_op),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== hdl/sqe_back.sv =====
// ----------------------------------------------------------------------------
// sqe_back
// Execution back end: owns the entry store (circular buffer with top pointer
// and entry count) and the mode register, and carries out each request.
// ----------------------------------------------------------------------------
module sqe_back #(
  parameter int unsigned DEPTH = sqe_pkg::STORE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_mode_i,
  input  sqe_pkg::cmd_t  cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output sqe_pkg::res_t  res_o
);

  import sqe_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PEEK    = 3'd1;
  localparam logic [2:0] S_SWAP_B  = 3'd2;
  localparam logic [2:0] S_SWAP_WA = 3'd3;
  localparam logic [2:0] S_SWAP_WB = 3'd4;
  localparam logic [2:0] S_DUMP_RD = 3'd5;
  localparam logic [2:0] S_DUMP_EM = 3'd6;

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rd_q;
  logic [31:0]   tmp_q, tmp_d;
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] top_q, top_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          mode_q;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;

  logic [AW-1:0] top_m1, top_p1;
  logic          store_empty, store_full, store_short, dump_last;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign top_m1      = (top_q == '0) ? AW'(DEPTH - 1) : top_q - 1'b1;
  assign top_p1      = wrap_add(top_q, AW'(1));
  assign store_empty = (cnt_q == '0);
  assign store_full  = (cnt_q == CW'(DEPTH));
  assign store_short = (cnt_q < CW'(2));
  assign dump_last   = ((CW'(idx_q) + 1'b1) == cnt_q);

  always_comb begin
    state_d    = state_q;
    top_d      = top_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    tmp_d      = tmp_q;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    mem_re     = 1'b0;
    mem_ra     = '0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{value: '0, status: ST_OK, last: 1'b1};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_PUSH: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                if (!cmd_i.arg_valid) begin
                  res_o.status = ST_BADARG;
                end else if (store_full) begin
                  res_o.status = ST_FULL;
                end else begin
                  mem_we = 1'b1;
                  mem_wd = cmd_i.value;
                  cnt_d  = cnt_q + 1'b1;
                  if (mode_q && !store_empty) begin
                    // queue mode: append below the bottom entry
                    mem_wa = wrap_add(top_q, cnt_q[AW-1:0]);
                  end else begin
                    mem_wa = top_m1;
                    top_d  = top_m1;
                  end
                end
              end
            end
            OP_POP: begin
              if (!res_full_i) begin
                res_push_o = 1'b1;
                cmd_pop_o  = 1'b1;
                if (store_empty) begin
                  res_o.status = ST_EMPTY;
                end else begin
                  top_d = top_p1;
                  cnt_d = cnt_q - 1'b1;
                end
              end
            end
            OP_SWAP: begin
              if (store_short) begin
                if (!res_full_i) begin
                  res_push_o   = 1'b1;
                  cmd_pop_o    = 1'b1;
                  res_o.status = ST_SHORT;
                end
              end else begin
                mem_re  = 1'b1;
                mem_ra  = top_q;
                state_d = S_SWAP_B;
              end
            end
            OP_PEEK: begin
              if (store_empty) begin
                if (!res_full_i) begin
                  res_push_o   = 1'b1;
                  cmd_pop_o    = 1'b1;
                  res_o.status = ST_EMPTY;
                end
              end else begin
                mem_re  = 1'b1;
                mem_ra  = top_q;
                state_d = S_PEEK;
              end
            end
            OP_DUMP: begin
              if (store_empty) begin
                if (!res_full_i) begin
                  res_push_o   = 1'b1;
                  cmd_pop_o    = 1'b1;
                  res_o.status = ST_DUMPEMPTY;
                end
              end else begin
                idx_d   = '0;
                state_d = S_DUMP_RD;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        if (!res_full_i) begin
          res_push_o  = 1'b1;
          cmd_pop_o   = 1'b1;
          res_o.value = rd_q;
          state_d     = S_IDLE;
        end
      end
      S_SWAP_B: begin
        // hold the top entry while the second one is read
        tmp_d   = rd_q;
        mem_re  = 1'b1;
        mem_ra  = top_p1;
        state_d = S_SWAP_WA;
      end
      S_SWAP_WA: begin
        mem_we  = 1'b1;
        mem_wa  = top_q;
        mem_wd  = rd_q;
        state_d = S_SWAP_WB;
      end
      S_SWAP_WB: begin
        if (!res_full_i) begin
          mem_we     = 1'b1;
          mem_wa     = top_p1;
          mem_wd     = tmp_q;
          res_push_o = 1'b1;
          cmd_pop_o  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        mem_re  = 1'b1;
        mem_ra  = wrap_add(top_q, idx_q);
        state_d = S_DUMP_EM;
      end
      S_DUMP_EM: begin
        if (!res_full_i) begin
          res_push_o  = 1'b1;
          res_o.value = rd_q;
          res_o.last  = dump_last;
          if (dump_last) begin
            cmd_pop_o = 1'b1;
            state_d   = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

endmodule
